// File: rtl/ordered_list_append_remove_macros.svh
// Assertion macros for the ordered list block
`ifndef ORDERED_LIST_APPEND_REMOVE_MACROS_SVH
`define ORDERED_LIST_APPEND_REMOVE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define OLAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define OLAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/olar_pkg.sv
// Shared constants and types for the ordered list block
`timescale 1ns / 1ps
`default_nettype none

package olar_pkg;

    // Number of cells in the chain
    localparam int LIST_DEPTH = 32;
    localparam int COUNT_W    = $clog2(LIST_DEPTH + 1);
    localparam int STEP_W     = $clog2(LIST_DEPTH);

    // Opcodes
    localparam logic [1:0] OP_APPEND   = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_DUMP_FWD = 2'd2;
    localparam logic [1:0] OP_DUMP_REV = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic               has_value;
        logic [1:0]         status;
        logic               last;
    } out_item_t;

    // Broadcast command to every cell of the chain
    typedef struct packed {
        logic               append_en;
        logic               remove_en;
        logic               rot_left;
        logic               rot_right;
        logic signed [31:0] key;
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/ordered_list_append_remove.sv
// Top level of the ordered list: control sequencer, cell chain and result register
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of up to LIST_DEPTH signed 32-bit entries held in a ring
// of cells, head in the first cell. An item is taken only while the block is
// idle. Then an append loads the key into the cell just past the tail, and a
// remove has every cell compare the key at once, the cells from the first match
// onward taking their right neighbour's entry; both wait for room in the result
// register. A dump of an empty list only reports the empty status. A dump of a
// non-empty list rotates the whole ring once round whatever the fill, to emit
// the entries in order and bring them back to their places; results come out in
// the first fill-count rotation steps (forward) or the last ones (reverse). The
// rotation stalls while a result is due and the result register is still full
// and not being taken. Appends to a full list and removes of an absent key leave
// the list as it was and report it in the status field. No clearing pass
// follows reset.

`include "ordered_list_append_remove_macros.svh"

module ordered_list_append_remove (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire olar_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output olar_pkg::out_item_t      out_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    localparam int                       COUNT_W = olar_pkg::COUNT_W;
    localparam int                       STEP_W  = olar_pkg::STEP_W;
    localparam int                       DEPTH   = olar_pkg::LIST_DEPTH;
    localparam logic [COUNT_W-1:0]       FULL_CNT = COUNT_W'(DEPTH);
    localparam logic [STEP_W-1:0]        LAST_STEP = STEP_W'(DEPTH - 1);

    logic                   state_reg;
    logic                   state_next;
    logic [1:0]             op_reg;
    logic signed [31:0]     key_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    olar_pkg::out_item_t    out_data_reg;
    olar_pkg::out_item_t    res;
    logic                   emit;
    logic                   slot_free;
    logic                   in_xfer;
    logic                   list_full;
    logic                   list_empty;
    logic                   found;
    logic                   fwd;
    logic [COUNT_W-1:0]     step_ext;
    logic                   dump_hit;
    logic                   dump_last;
    olar_pkg::cell_cmd_t    cmd;

    logic signed [31:0]     cell_val [DEPTH];
    logic [DEPTH:0]         hit;
    logic [DEPTH-1:0]       live;
    logic [DEPTH-1:0]       tail_slot;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign list_full  = (count_reg == FULL_CNT);
    assign list_empty = (count_reg == '0);
    assign found      = hit[DEPTH];

    // Dump position: forward emits from the head cell, reverse from the last cell
    assign fwd       = (op_reg == olar_pkg::OP_DUMP_FWD);
    assign step_ext  = COUNT_W'(step_reg);
    assign dump_hit  = fwd ? (step_ext < count_reg) : (step_ext >= (FULL_CNT - count_reg));
    assign dump_last = fwd ? (step_ext == (count_reg - COUNT_W'(1))) : (step_reg == LAST_STEP);

    // Build the chain of cells as a ring
    assign hit[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign live[gi]      = (COUNT_W'(gi) < count_reg);
            assign tail_slot[gi] = (COUNT_W'(gi) == count_reg);

            olar_cell u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .live      (live[gi]),
                .tail_slot (tail_slot[gi]),
                .left_val  (cell_val[(gi + DEPTH - 1) % DEPTH]),
                .right_val (cell_val[(gi + 1) % DEPTH]),
                .hit_in    (hit[gi]),
                .val       (cell_val[gi]),
                .hit_out   (hit[gi+1])
            );
        end
    endgenerate

    // Sequence one item through the chain
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        cmd           = '0;
        cmd.key       = key_reg;
        emit          = 1'b0;
        res           = '0;
        res.status    = olar_pkg::ST_OK;
        res.last      = 1'b1;
        if (state_reg == S_EXEC)
        begin
            case (op_reg)
                olar_pkg::OP_APPEND:
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (list_full)
                        begin
                            res.status = olar_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.append_en = 1'b1;
                            count_next    = count_reg + COUNT_W'(1);
                        end
                    end
                end
                olar_pkg::OP_REMOVE:
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (list_empty)
                        begin
                            res.status = olar_pkg::ST_EMPTY;
                        end
                        else if (!found)
                        begin
                            res.status = olar_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.remove_en = 1'b1;
                            count_next    = count_reg - COUNT_W'(1);
                        end
                    end
                end
                olar_pkg::OP_DUMP_FWD, olar_pkg::OP_DUMP_REV:
                begin
                    if (list_empty)
                    begin
                        if (slot_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            res.status = olar_pkg::ST_EMPTY;
                        end
                    end
                    else if (!dump_hit || slot_free)
                    begin
                        // Rotate one place; stall only when an entry must go out
                        cmd.rot_left  = fwd;
                        cmd.rot_right = !fwd;
                        step_next     = step_reg + STEP_W'(1);
                        if (step_reg == LAST_STEP)
                        begin
                            state_next = S_IDLE;
                        end
                        if (dump_hit)
                        begin
                            emit           = 1'b1;
                            res.item_value = fwd ? cell_val[0] : cell_val[DEPTH-1];
                            res.has_value  = 1'b1;
                            res.last       = dump_last;
                        end
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
        else if (in_xfer)
        begin
            state_next = S_EXEC;
            step_next  = '0;
        end
    end

    assign out_valid_next = emit || (out_valid_reg && !out_ready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the item and the result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= in_data.opcode;
            key_reg <= in_data.value;
        end
        if (emit)
        begin
            out_data_reg <= res;
        end
    end

    `OLAR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_CNT, "entry count above depth")
    `OLAR_ASSERT_NEXT(a_idle_count, state_reg == S_IDLE, $stable(count_reg), "count moved while idle")
    `OLAR_ASSERT_NEXT(a_take_exec, in_xfer, (state_reg == S_EXEC) && !in_ready, "item taken but no work")
    `OLAR_ASSERT_NOW(a_emit_room, emit, slot_free, "result written over a waiting one")

endmodule

`default_nettype wire

// File: rtl/olar_cell.sv
// One storage cell of the list chain: holds an entry, matches the key, shifts
`timescale 1ns / 1ps
`default_nettype none

module olar_cell (
    input  wire logic               clk,
    input  wire olar_pkg::cell_cmd_t cmd,
    input  wire logic               live,
    input  wire logic               tail_slot,
    input  wire logic signed [31:0] left_val,
    input  wire logic signed [31:0] right_val,
    input  wire logic               hit_in,
    output logic signed [31:0]      val,
    output logic                    hit_out
);

    logic signed [31:0] val_reg;
    logic signed [31:0] val_next;
    logic               match;

    // Match only entries inside the list, and pass the first-match mark on
    assign match   = live && (val_reg == cmd.key);
    assign hit_out = hit_in || match;
    assign val     = val_reg;

    // Pick the next content: load, close the gap, rotate or hold
    always_comb
    begin
        val_next = val_reg;
        if (cmd.append_en && tail_slot)
        begin
            val_next = cmd.key;
        end
        else if (cmd.remove_en && hit_out)
        begin
            val_next = right_val;
        end
        else if (cmd.rot_left)
        begin
            val_next = right_val;
        end
        else if (cmd.rot_right)
        begin
            val_next = left_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_ordered_list_append_remove.sv
// Testbench for the ordered list block: directed and random stimulus checked by a list predictor
`timescale 1ns / 1ps

module tb_ordered_list_append_remove;

    typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} stim_mode_e;

    // Predicted list contents and the results still owed by the block
    class list_scoreboard;
        logic signed [31:0]  cells[$];
        olar_pkg::out_item_t owed_q[$];
        int                  errors;

        function new();
            errors = 0;
        endfunction

        // Work out every result that one accepted transfer causes
        function void note_input(olar_pkg::in_item_t it);
            olar_pkg::out_item_t r;
            int                  idx;
            int                  n;
            r      = '0;
            r.last = 1'b1;
            n      = cells.size();
            case (it.opcode)
                olar_pkg::OP_APPEND:
                begin
                    if (n >= olar_pkg::LIST_DEPTH)
                    begin
                        r.status = olar_pkg::ST_FULL;
                    end
                    else
                    begin
                        cells.push_back(it.value);
                        r.status = olar_pkg::ST_OK;
                    end
                    owed_q.push_back(r);
                end
                olar_pkg::OP_REMOVE:
                begin
                    if (n == 0)
                    begin
                        r.status = olar_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // Find the first match from the head
                        idx = -1;
                        for (int i = 0; i < n; i++)
                        begin
                            if (idx < 0 && cells[i] == it.value)
                                idx = i;
                        end
                        if (idx < 0)
                        begin
                            r.status = olar_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            cells.delete(idx);
                            r.status = olar_pkg::ST_OK;
                        end
                    end
                    owed_q.push_back(r);
                end
                default:
                begin
                    if (n == 0)
                    begin
                        r.status = olar_pkg::ST_EMPTY;
                        owed_q.push_back(r);
                    end
                    else
                    begin
                        // Emit every entry, head first or tail first
                        for (int i = 0; i < n; i++)
                        begin
                            r.item_value = (it.opcode == olar_pkg::OP_DUMP_FWD)
                                           ? cells[i] : cells[n - 1 - i];
                            r.has_value  = 1'b1;
                            r.status     = olar_pkg::ST_OK;
                            r.last       = (i == n - 1);
                            owed_q.push_back(r);
                        end
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest one owed
        task check_result(olar_pkg::out_item_t got);
            olar_pkg::out_item_t want;
            if (owed_q.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
            end
            else
            begin
                want = owed_q.pop_front();
                if (got.item_value !== want.item_value)
                    report($sformatf("item_value %h, want %h", got.item_value, want.item_value));
                if (got.has_value !== want.has_value)
                    report($sformatf("has_value %b, want %b", got.has_value, want.has_value));
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.last !== want.last)
                    report($sformatf("last %b, want %b", got.last, want.last));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    olar_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    olar_pkg::out_item_t out_data;

    list_scoreboard sb;
    bit             tx_burst;
    bit             rx_hold_req;

    ordered_list_append_remove dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Offer one item after a drawn gap and hold it until the transfer
    task automatic send_item(logic [1:0] op, logic signed [31:0] val);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_data.opcode <= op;
        in_data.value  <= val;
        do @(posedge clk); while (!in_ready);
        sb.note_input(in_data);
    endtask

    // Mostly fresh random values, some small ones for duplicates, some extremes
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        else if (r < 8)
            return $urandom_range(0, 7);
        else
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (sb.cells.size() > 0 && $urandom_range(0, 9) < 8)
            return sb.cells[$urandom_range(0, sb.cells.size() - 1)];
        return pick_value();
    endfunction

    // Build one item biased by the phase of the run
    task automatic send_random(stim_mode_e mode);
        int         r;
        logic [1:0] dump_op;
        r       = $urandom_range(0, 99);
        dump_op = $urandom_range(0, 1) ? olar_pkg::OP_DUMP_FWD : olar_pkg::OP_DUMP_REV;
        case (mode)
            MODE_FILL:
                if (r < 90)      send_item(olar_pkg::OP_APPEND, pick_value());
                else if (r < 95) send_item(dump_op, $urandom);
                else             send_item(2'($urandom_range(0, 3)), $urandom);
            MODE_DRAIN:
                if (r < 85)      send_item(olar_pkg::OP_REMOVE, pick_key());
                else if (r < 88) send_item(olar_pkg::OP_APPEND, pick_value());
                else if (r < 95) send_item(dump_op, $urandom);
                else             send_item(2'($urandom_range(0, 3)), $urandom);
            default:
                if (r < 35)      send_item(olar_pkg::OP_APPEND, pick_value());
                else if (r < 70) send_item(olar_pkg::OP_REMOVE, pick_key());
                else if (r < 90) send_item(dump_op, $urandom);
                else             send_item(2'($urandom_range(0, 3)), $urandom);
        endcase
    endtask

    task automatic run_directed();
        // Empty list on both dumps and a remove
        send_item(olar_pkg::OP_DUMP_FWD, 32'sd0);
        send_item(olar_pkg::OP_DUMP_REV, 32'sd0);
        send_item(olar_pkg::OP_REMOVE, 32'sd0);
        // Extremes and a duplicate
        send_item(olar_pkg::OP_APPEND, 32'sh8000_0000);
        send_item(olar_pkg::OP_APPEND, 32'sh7fff_ffff);
        send_item(olar_pkg::OP_APPEND, 32'sd0);
        send_item(olar_pkg::OP_APPEND, -32'sd1);
        send_item(olar_pkg::OP_APPEND, 32'sd5);
        send_item(olar_pkg::OP_APPEND, 32'sd5);
        send_item(olar_pkg::OP_DUMP_FWD, 32'sd0);
        send_item(olar_pkg::OP_DUMP_REV, 32'sd0);
        // Absent key, first of two matches, head, middle
        send_item(olar_pkg::OP_REMOVE, 32'sd123);
        send_item(olar_pkg::OP_REMOVE, 32'sd5);
        send_item(olar_pkg::OP_REMOVE, 32'sh8000_0000);
        send_item(olar_pkg::OP_REMOVE, -32'sd1);
        send_item(olar_pkg::OP_DUMP_FWD, 32'sd0);
        // Tail, then down to a single entry and empty again
        send_item(olar_pkg::OP_REMOVE, 32'sd5);
        send_item(olar_pkg::OP_REMOVE, 32'sh7fff_ffff);
        send_item(olar_pkg::OP_REMOVE, 32'sd0);
        send_item(olar_pkg::OP_DUMP_REV, 32'sd0);
        // Alternating bit patterns; dumps ignore the value field
        send_item(olar_pkg::OP_APPEND, 32'sh5555_5555);
        send_item(olar_pkg::OP_APPEND, 32'shaaaa_aaaa);
        send_item(olar_pkg::OP_DUMP_FWD, -32'sd1);
        send_item(olar_pkg::OP_DUMP_REV, 32'sh5555_5555);
    endtask

    task automatic run_segment(stim_mode_e mode);
        tx_burst = ($urandom_range(0, 3) == 0);
        case (mode)
            MODE_FILL:
            begin
                while (sb.cells.size() < olar_pkg::LIST_DEPTH)
                    send_random(MODE_FILL);
                // Overflow the full list, then dump it both ways
                repeat (3) send_item(olar_pkg::OP_APPEND, pick_value());
                send_item(olar_pkg::OP_DUMP_FWD, $urandom);
                send_item(olar_pkg::OP_DUMP_REV, $urandom);
            end
            MODE_DRAIN:
            begin
                while (sb.cells.size() > 0)
                    send_random(MODE_DRAIN);
                repeat (2) send_item(olar_pkg::OP_REMOVE, pick_value());
            end
            default:
                repeat (12) send_random(MODE_MIX);
        endcase
    endtask

    // Receiver: drawn gaps, bursts with none, and one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 11);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                gap         = 400;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        sb          = new();
        tx_burst    = 1'b0;
        rx_hold_req = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_segment(MODE_FILL);
        // Stall the receiver while the sender keeps offering
        rx_hold_req = 1'b1;
        run_segment(MODE_MIX);
        run_segment(MODE_DRAIN);
        in_valid <= 1'b0;

        // Drain the owed results, then allow for a trailing dump
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (4 * olar_pkg::LIST_DEPTH) @(posedge clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
